FILE: hdl/tsp_pkg.sv
// Shared types and constants for the target sentence parser.
// No dependencies; used by tsp_core and target_sentence_parser.
package tsp_pkg;

   localparam logic [7:0] CHAR_DOLLAR = 8'h24;
   localparam logic [7:0] CHAR_TEE    = 8'h54;
   localparam logic [7:0] CHAR_COMMA  = 8'h2C;
   localparam logic [7:0] CHAR_LF     = 8'h0A;
   localparam logic [7:0] CHAR_CR     = 8'h0D;
   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_TAB    = 8'h09;
   localparam logic [7:0] CHAR_VT     = 8'h0B;
   localparam logic [7:0] CHAR_FF     = 8'h0C;
   localparam logic [7:0] CHAR_PLUS   = 8'h2B;
   localparam logic [7:0] CHAR_MINUS  = 8'h2D;
   localparam logic [7:0] CHAR_ZERO   = 8'h30;
   localparam logic [7:0] CHAR_NINE   = 8'h39;

   localparam logic [31:0] SAT_MAG = 32'h8000_0000;
   localparam logic [35:0] SAT_MAG_WIDE = 36'h0_8000_0000;

   localparam logic [1:0] FIELD_X = 2'd0;
   localparam logic [1:0] FIELD_Y = 2'd1;
   localparam logic [1:0] FIELD_V = 2'd2;

   typedef enum logic [6:0] {
      PH_DOLLAR = 7'b0000001,
      PH_TEE    = 7'b0000010,
      PH_COMMA  = 7'b0000100,
      PH_LEAD   = 7'b0001000,
      PH_SIGN   = 7'b0010000,
      PH_DIGITS = 7'b0100000,
      PH_DONE   = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic        valid;
      logic [15:0] x_error;
      logic [15:0] y_error;
      logic        target_valid;
      logic [31:0] stamp_ms;
   } result_type;

endpackage

FILE: hdl/tsp_core.sv
// Sentence parser state and per-byte update logic.
// Depends on tsp_pkg; instantiated by target_sentence_parser.
module tsp_core #(
   parameter int LINE_CAPACITY = 48
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   input  logic [31:0]         now_ms,
   output tsp_pkg::result_type result
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_LAST = LEN_W'(LINE_CAPACITY - 1);

   logic [LEN_W-1:0]   len_ff, len_in;
   tsp_pkg::phase_type phase_ff, phase_in;
   logic [1:0]         field_ff, field_in;
   logic               started_ff, started_in;
   logic               neg_ff, neg_in;
   logic [31:0]        acc_ff, acc_in;
   logic [15:0]        held_x_ff, held_x_in;
   logic [15:0]        held_y_ff, held_y_in;
   logic               bad_ff, bad_in;

   logic        is_term, is_digit, is_blank, is_sign;
   logic [35:0] acc_wide;
   logic [31:0] acc_next;
   logic [15:0] low16;
   logic        emit;

   assign is_term  = (rx_byte == tsp_pkg::CHAR_CR) || (rx_byte == tsp_pkg::CHAR_LF);
   assign is_digit = (rx_byte >= tsp_pkg::CHAR_ZERO) && (rx_byte <= tsp_pkg::CHAR_NINE);
   assign is_blank = (rx_byte == tsp_pkg::CHAR_SPACE) || (rx_byte == tsp_pkg::CHAR_TAB)
                  || (rx_byte == tsp_pkg::CHAR_VT) || (rx_byte == tsp_pkg::CHAR_FF);
   assign is_sign  = (rx_byte == tsp_pkg::CHAR_PLUS) || (rx_byte == tsp_pkg::CHAR_MINUS);

   // acc * 10 + digit, saturated at 2^31
   assign acc_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + {32'd0, rx_byte[3:0] - tsp_pkg::CHAR_ZERO[3:0]};
   assign acc_next = (acc_wide > tsp_pkg::SAT_MAG_WIDE) ? tsp_pkg::SAT_MAG : acc_wide[31:0];

   always_comb begin
      if (neg_ff) begin
         low16 = 16'd0 - acc_ff[15:0];
      end else if (acc_ff >= tsp_pkg::SAT_MAG) begin
         low16 = 16'hFFFF;
      end else begin
         low16 = acc_ff[15:0];
      end
   end

   assign emit = !bad_ff && ((phase_ff == tsp_pkg::PH_DONE)
              || ((field_ff == tsp_pkg::FIELD_V) && ((phase_ff == tsp_pkg::PH_LEAD)
              || (phase_ff == tsp_pkg::PH_SIGN) || (phase_ff == tsp_pkg::PH_DIGITS))));

   always_comb begin
      logic clear;
      logic close;
      clear      = 1'b0;
      close      = 1'b0;
      len_in     = len_ff;
      phase_in   = phase_ff;
      field_in   = field_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      acc_in     = acc_ff;
      held_x_in  = held_x_ff;
      held_y_in  = held_y_ff;
      bad_in     = bad_ff;
      result.valid        = 1'b0;
      result.x_error      = held_x_ff;
      result.y_error      = held_y_ff;
      result.target_valid = (acc_ff != 32'd0);
      result.stamp_ms     = now_ms;

      if (is_term) begin
         if (len_ff != '0) begin
            result.valid = emit;
            clear        = 1'b1;
         end
      end else if (len_ff < LEN_LAST) begin
         len_in = len_ff + 1'b1;
         if (!bad_ff && (phase_ff != tsp_pkg::PH_DONE)) begin
            unique case (phase_ff)
               tsp_pkg::PH_DOLLAR: begin
                  if (rx_byte == tsp_pkg::CHAR_DOLLAR) phase_in = tsp_pkg::PH_TEE;
                  else bad_in = 1'b1;
               end
               tsp_pkg::PH_TEE: begin
                  if (rx_byte == tsp_pkg::CHAR_TEE) phase_in = tsp_pkg::PH_COMMA;
                  else bad_in = 1'b1;
               end
               tsp_pkg::PH_COMMA: begin
                  if (rx_byte == tsp_pkg::CHAR_COMMA) begin
                     phase_in   = tsp_pkg::PH_LEAD;
                     field_in   = tsp_pkg::FIELD_X;
                     started_in = 1'b0;
                     neg_in     = 1'b0;
                     acc_in     = 32'd0;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               tsp_pkg::PH_LEAD: begin
                  priority if (is_blank) begin
                     started_in = 1'b1;
                  end else if (is_sign) begin
                     neg_in   = (rx_byte == tsp_pkg::CHAR_MINUS);
                     phase_in = tsp_pkg::PH_SIGN;
                  end else if (is_digit) begin
                     acc_in   = acc_next;
                     phase_in = tsp_pkg::PH_DIGITS;
                  end else if (field_ff == tsp_pkg::FIELD_V) begin
                     phase_in = tsp_pkg::PH_DONE;
                  end else if ((rx_byte == tsp_pkg::CHAR_COMMA) && !started_ff) begin
                     close = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               tsp_pkg::PH_SIGN: begin
                  priority if (is_digit) begin
                     acc_in   = acc_next;
                     phase_in = tsp_pkg::PH_DIGITS;
                  end else if (field_ff == tsp_pkg::FIELD_V) begin
                     phase_in = tsp_pkg::PH_DONE;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               tsp_pkg::PH_DIGITS: begin
                  priority if (is_digit) begin
                     acc_in = acc_next;
                  end else if (field_ff == tsp_pkg::FIELD_V) begin
                     phase_in = tsp_pkg::PH_DONE;
                  end else if (rx_byte == tsp_pkg::CHAR_COMMA) begin
                     close = 1'b1;
                  end else begin
                     bad_in = 1'b1;
                  end
               end
               default: begin
                  bad_in = 1'b1;
               end
            endcase
         end
      end else begin
         clear = 1'b1;
      end

      if (close) begin
         if (field_ff == tsp_pkg::FIELD_X) held_x_in = low16;
         else held_y_in = low16;
         field_in   = field_ff + 1'b1;
         phase_in   = tsp_pkg::PH_LEAD;
         started_in = 1'b0;
         neg_in     = 1'b0;
         acc_in     = 32'd0;
      end

      if (clear) begin
         len_in     = '0;
         phase_in   = tsp_pkg::PH_DOLLAR;
         field_in   = tsp_pkg::FIELD_X;
         started_in = 1'b0;
         neg_in     = 1'b0;
         acc_in     = 32'd0;
         bad_in     = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff     <= '0;
         phase_ff   <= tsp_pkg::PH_DOLLAR;
         field_ff   <= tsp_pkg::FIELD_X;
         started_ff <= 1'b0;
         neg_ff     <= 1'b0;
         acc_ff     <= 32'd0;
         held_x_ff  <= 16'd0;
         held_y_ff  <= 16'd0;
         bad_ff     <= 1'b0;
      end else if (step) begin
         len_ff     <= len_in;
         phase_ff   <= phase_in;
         field_ff   <= field_in;
         started_ff <= started_in;
         neg_ff     <= neg_in;
         acc_ff     <= acc_in;
         held_x_ff  <= held_x_in;
         held_y_ff  <= held_y_in;
         bad_ff     <= bad_in;
      end
   end

   a_len_range: assert property (@(posedge clock) disable iff (reset)
      len_ff <= LEN_LAST)
      else $error("line length beyond capacity");

   a_term_clears: assert property (@(posedge clock) disable iff (reset)
      step && is_term |=> (len_ff == '0) && (phase_ff == tsp_pkg::PH_DOLLAR) && !bad_ff)
      else $error("terminator did not clear the line");

   a_result_on_term: assert property (@(posedge clock) disable iff (reset)
      result.valid |-> is_term && (len_ff != '0) && !bad_ff)
      else $error("result without a terminator on a good line");

   a_field_range: assert property (@(posedge clock) disable iff (reset)
      field_ff != 2'd3)
      else $error("field index out of range");

   a_acc_sat: assert property (@(posedge clock) disable iff (reset)
      acc_ff <= tsp_pkg::SAT_MAG)
      else $error("magnitude above saturation");

endmodule

FILE: hdl/target_sentence_parser.sv
// The terminator is held in the input register, its result in the result register.
// Throughput: one byte per cycle while the output is not stalled; the parser state
// updates once per byte in a single pass between the input and result registers.
// Reset: synchronous, active high; empties both registers, clears the line
// state and the held x and y values.
module target_sentence_parser #(
   parameter int LINE_CAPACITY = 48
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // rx_byte[7:0], now_ms[39:8]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata    // x_error[15:0], y_error[31:16], target_valid[32],
                                    // stamp_ms[64:33], zero[71:65]
);

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   logic [31:0] in_now_ff;
   logic        step;
   logic        out_valid_ff;
   logic [64:0] out_data_ff;
   tsp_pkg::result_type res;

   assign step       = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_byte_ff <= req_tdata[7:0];
         in_now_ff  <= req_tdata[39:8];
      end
   end

   tsp_core #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .step   (step),
      .rx_byte(in_byte_ff),
      .now_ms (in_now_ff),
      .result (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         out_valid_ff <= step && res.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (step && res.valid) begin
         out_data_ff <= {res.stamp_ms, res.target_valid, res.y_error, res.x_error};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {7'd0, out_data_ff};

endmodule
